@@ src/wfs_pkg.sv @@
package wfs_pkg;

  // strip length and derived widths
  localparam int LED_COUNT = 64;
  localparam int ADDR_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int IDX_W     = 10;
  localparam int COLOUR_W  = 24;
  localparam int BIT_CNT_W = 5;
  localparam int PHASE_W   = 16;
  localparam int TIME_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [IDX_W-1:0]     LAST_LED  = IDX_W'(LED_COUNT - 1);
  localparam logic [IDX_W:0]       LED_LIMIT = (IDX_W + 1)'(LED_COUNT);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT  = BIT_CNT_W'(COLOUR_W - 1);

  // command codes
  localparam logic [2:0] CMD_IDLE    = 3'd0;
  localparam logic [2:0] CMD_CLEAR   = 3'd1;
  localparam logic [2:0] CMD_SET_ALL = 3'd2;
  localparam logic [2:0] CMD_SET_ONE = 3'd3;
  localparam logic [2:0] CMD_SHOW    = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 3'd4;

  // register reset values
  localparam logic [TIME_W-1:0]  ONE_HIGH_RST  = 8'd13;
  localparam logic [TIME_W-1:0]  ONE_LOW_RST   = 8'd11;
  localparam logic [TIME_W-1:0]  ZERO_HIGH_RST = 8'd7;
  localparam logic [TIME_W-1:0]  ZERO_LOW_RST  = 8'd16;
  localparam logic [PHASE_W-1:0] LATCH_RST     = 16'd960;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

endpackage

@@ src/wfs_ram.sv @@
module wfs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/ws2812_frame_serializer_top.sv @@
// the result beat of an input beat is registered and offered in the cycle after it is taken
// throughput: one input and one result beat per cycle unless out_stall holds; one output register sets this
// every command, set all and clear all included, finishes within its own beat, but show starts a frame
// reset (rst, synchronous): control registers go to their defaults, the frame store reads as all zero
// at once through per-entry valid bits, so there is no clearing pass after reset
module ws2812_frame_serializer_top (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     command,
  input  logic [wfs_pkg::IDX_W-1:0]      led_index,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           data_line,
  output logic                           busy_res,
  output logic                           rejected,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wfs_pkg::CFG_DAT_W-1:0]  cfg_data
);

  // timing registers
  logic [wfs_pkg::TIME_W-1:0]  one_high_cycles;
  logic [wfs_pkg::TIME_W-1:0]  one_low_cycles;
  logic [wfs_pkg::TIME_W-1:0]  zero_high_cycles;
  logic [wfs_pkg::TIME_W-1:0]  zero_low_cycles;
  logic [wfs_pkg::PHASE_W-1:0] latch_cycles;

  // serializer state
  wfs_pkg::phase_t                phase, phase_next, ph_eff;
  logic [wfs_pkg::PHASE_W-1:0]    phase_counter, phase_counter_next, pc_eff, pc_inc;
  logic [wfs_pkg::BIT_CNT_W-1:0]  bit_counter, bit_counter_next, bc_eff;
  logic [wfs_pkg::IDX_W-1:0]      led_counter, led_counter_next, lc_eff;
  logic [wfs_pkg::COLOUR_W-1:0]   shift_word, shift_word_next, sw_eff;
  logic [wfs_pkg::TIME_W-1:0]     bit_len;

  // frame store: ram plus fill colour and per-entry valid bits, so clear all and set all
  // only rewrite the fill colour and the entry zero shadow and drop the valid bits
  logic [wfs_pkg::COLOUR_W-1:0]   fill_colour;
  logic [wfs_pkg::LED_COUNT-1:0]  entry_valid;
  logic [wfs_pkg::COLOUR_W-1:0]   head_word;    // shadow of entry zero, needed on the show beat
  logic [wfs_pkg::COLOUR_W-1:0]   colour;
  logic                           st_we;
  logic [wfs_pkg::ADDR_W-1:0]     rd_addr;
  logic [wfs_pkg::IDX_W:0]        lc_plus;
  logic [wfs_pkg::COLOUR_W-1:0]   rd_data;
  logic                           rd_valid;
  logic [wfs_pkg::COLOUR_W-1:0]   next_word;

  logic accept;
  logic idle;
  logic in_range;
  logic line_next, busy_next, rejected_next;

  // handshake: one output register parts the two sides
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign idle     = (phase == wfs_pkg::PH_IDLE);
  assign colour   = {green, red, blue};
  assign in_range = ({1'b0, led_index} < wfs_pkg::LED_LIMIT);
  assign st_we    = accept & idle & (command == wfs_pkg::CMD_SET_ONE) & in_range;

  // the next led's word is read continuously; the store cannot change while busy
  // and an led boundary is always many beats after the counter moves
  assign lc_plus   = {1'b0, led_counter} + 1'b1;
  assign rd_addr   = lc_plus[wfs_pkg::ADDR_W-1:0];
  assign next_word = rd_valid ? rd_data : fill_colour;

  wfs_ram #(
    .WIDTH (wfs_pkg::COLOUR_W),
    .DEPTH (wfs_pkg::LED_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (led_index[wfs_pkg::ADDR_W-1:0]),
    .wdata (colour),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= entry_valid[rd_addr];
    end
  end

  // store bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_colour <= '0;
      entry_valid <= '0;
      head_word   <= '0;
    end else if (accept && idle) begin
      case (command)
        wfs_pkg::CMD_CLEAR: begin
          fill_colour <= '0;
          entry_valid <= '0;
          head_word   <= '0;
        end
        wfs_pkg::CMD_SET_ALL: begin
          fill_colour <= colour;
          entry_valid <= '0;
          head_word   <= colour;
        end
        wfs_pkg::CMD_SET_ONE: begin
          if (in_range) begin
            entry_valid[led_index[wfs_pkg::ADDR_W-1:0]] <= 1'b1;
            if (led_index == '0) begin
              head_word <= colour;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      one_high_cycles  <= wfs_pkg::ONE_HIGH_RST;
      one_low_cycles   <= wfs_pkg::ONE_LOW_RST;
      zero_high_cycles <= wfs_pkg::ZERO_HIGH_RST;
      zero_low_cycles  <= wfs_pkg::ZERO_LOW_RST;
      latch_cycles     <= wfs_pkg::LATCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wfs_pkg::REG_ONE_HIGH:  one_high_cycles  <= cfg_data[wfs_pkg::TIME_W-1:0];
        wfs_pkg::REG_ONE_LOW:   one_low_cycles   <= cfg_data[wfs_pkg::TIME_W-1:0];
        wfs_pkg::REG_ZERO_HIGH: zero_high_cycles <= cfg_data[wfs_pkg::TIME_W-1:0];
        wfs_pkg::REG_ZERO_LOW:  zero_low_cycles  <= cfg_data[wfs_pkg::TIME_W-1:0];
        wfs_pkg::REG_LATCH:     latch_cycles     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // show starts the frame in the same beat: first high cycle of the first bit
  always_comb begin
    ph_eff = phase;
    pc_eff = phase_counter;
    bc_eff = bit_counter;
    lc_eff = led_counter;
    sw_eff = shift_word;
    if (idle && command == wfs_pkg::CMD_SHOW) begin
      ph_eff = wfs_pkg::PH_HIGH;
      pc_eff = '0;
      bc_eff = '0;
      lc_eff = '0;
      sw_eff = head_word;
    end
  end

  // next state: advance the phase counters by one beat
  always_comb begin
    phase_next         = ph_eff;
    phase_counter_next = pc_eff;
    bit_counter_next   = bc_eff;
    led_counter_next   = lc_eff;
    shift_word_next    = sw_eff;
    pc_inc             = pc_eff + 1'b1;
    bit_len            = '0;
    case (ph_eff)
      wfs_pkg::PH_HIGH: begin
        bit_len = sw_eff[wfs_pkg::COLOUR_W-1] ? one_high_cycles : zero_high_cycles;
        if (pc_inc >= {8'd0, bit_len}) begin
          phase_next         = wfs_pkg::PH_LOW;
          phase_counter_next = '0;
        end else begin
          phase_counter_next = pc_inc;
        end
      end
      wfs_pkg::PH_LOW: begin
        bit_len = sw_eff[wfs_pkg::COLOUR_W-1] ? one_low_cycles : zero_low_cycles;
        if (pc_inc >= {8'd0, bit_len}) begin
          phase_counter_next = '0;
          shift_word_next    = {sw_eff[wfs_pkg::COLOUR_W-2:0], 1'b0};
          if (bc_eff >= wfs_pkg::LAST_BIT) begin
            bit_counter_next = '0;
            if (lc_eff >= wfs_pkg::LAST_LED) begin
              phase_next = wfs_pkg::PH_LATCH;
            end else begin
              led_counter_next = lc_eff + 1'b1;
              shift_word_next  = next_word;
              phase_next       = wfs_pkg::PH_HIGH;
            end
          end else begin
            bit_counter_next = bc_eff + 1'b1;
            phase_next       = wfs_pkg::PH_HIGH;
          end
        end else begin
          phase_counter_next = pc_inc;
        end
      end
      wfs_pkg::PH_LATCH: begin
        if (pc_inc >= latch_cycles) begin
          phase_counter_next = '0;
          led_counter_next   = '0;
          phase_next         = wfs_pkg::PH_IDLE;
        end else begin
          phase_counter_next = pc_inc;
        end
      end
      default: begin
      end
    endcase
  end

  // result of this beat
  always_comb begin
    line_next     = (ph_eff == wfs_pkg::PH_HIGH);
    busy_next     = (ph_eff != wfs_pkg::PH_IDLE);
    rejected_next = ~idle & (command != wfs_pkg::CMD_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= wfs_pkg::PH_IDLE;
      phase_counter <= '0;
      bit_counter   <= '0;
      led_counter   <= '0;
      shift_word    <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      phase_counter <= phase_counter_next;
      bit_counter   <= bit_counter_next;
      led_counter   <= led_counter_next;
      shift_word    <= shift_word_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_line <= line_next;
      busy_res  <= busy_next;
      rejected  <= rejected_next;
    end
  end

endmodule
